FILE: hdl/smcs_pkg.sv
// Shared types, codes and constants for the sparse matrix coordinate store.
package smcs_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_INDEX_BITS = 8;
  localparam int QUEUE_DEPTH    = 2;

  localparam int OP_W      = 3;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 3;
  localparam int CNT_REG_W = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_REG_W-1:0] COUNT_RESET = 9'd256;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_READ      = 3'd1,
    OP_ROW_SUM   = 3'd2,
    OP_COL_SUM   = 3'd3,
    OP_OVERWRITE = 3'd4,
    OP_CLEAR     = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_USED    = 3'd2,
    ST_FULL    = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 1'b0,
    CFG_COL_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    op_t  op;
    logic row_ok;
    logic col_ok;
  } cls_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_SCAN,
    BK_CLEAR,
    BK_FINISH
  } back_state_t;

endpackage

FILE: hdl/smcs_ifs.sv
// Request, response and configuration channel interfaces.
interface smcs_req_if import smcs_pkg::*; #(
  parameter int INDEX_BITS = DEF_INDEX_BITS
);
  logic                         valid;
  logic                         ready;
  logic [OP_W-1:0]              operation;
  logic [INDEX_BITS-1:0]        row_index;
  logic [INDEX_BITS-1:0]        col_index;
  logic signed [VALUE_W-1:0]    entry_value;

  modport source(output valid, operation, row_index, col_index, entry_value, input ready);
  modport sink(input valid, operation, row_index, col_index, entry_value, output ready);
endinterface

interface smcs_rsp_if import smcs_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] result_value;
  logic [STATUS_W-1:0]       status;
  logic                      saturated;

  modport source(output valid, result_value, status, saturated, input ready);
  modport sink(input valid, result_value, status, saturated, output ready);
endinterface

interface smcs_cfg_if import smcs_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CNT_REG_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: hdl/smcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module smcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/smcs_fifo.sv
// Short item queue between the front and back parts.
module smcs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [NW-1:0] FILL_MAX = NW'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != FILL_MAX);
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/smcs_front.sv
// Front part: configuration registers, item intake and range classification.
module smcs_front import smcs_pkg::*; #(
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  smcs_cfg_if.sink                                      cfg,
  smcs_req_if.sink                                      request,
  output logic                                          push_valid,
  input  logic                                          push_ready,
  output logic [$bits(cls_t)+2*INDEX_BITS+VALUE_W-1:0]  push_data,
  output logic [CNT_REG_W-1:0]                          row_count,
  output logic [CNT_REG_W-1:0]                          col_count
);

  localparam int CMPW = (INDEX_BITS + 1 > CNT_REG_W) ? INDEX_BITS + 1 : CNT_REG_W;

  cls_t cls;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= COUNT_RESET;
      col_count <= COUNT_RESET;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        CFG_ROW_COUNT: row_count <= cfg.data;
        CFG_COL_COUNT: col_count <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cls.op     = op_t'(request.operation);
    cls.row_ok = CMPW'(request.row_index) < CMPW'(row_count);
    cls.col_ok = CMPW'(request.col_index) < CMPW'(col_count);
  end

  assign push_valid    = request.valid;
  assign request.ready = push_ready;
  assign push_data     = {cls, request.row_index, request.col_index, request.entry_value};

endmodule

FILE: hdl/smcs_back.sv
// Back part: slot memory scan engine, sums, updates and result register.
module smcs_back import smcs_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          pop_valid,
  output logic                                          pop_ready,
  input  logic [$bits(cls_t)+2*INDEX_BITS+VALUE_W-1:0]  pop_data,
  input  logic [CNT_REG_W-1:0]                          row_count,
  input  logic [CNT_REG_W-1:0]                          col_count,
  smcs_rsp_if.source                                    response
);

  localparam int AW     = $clog2(CAPACITY);
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int WORD_W = 1 + 2 * INDEX_BITS + VALUE_W;
  localparam int ACC_W  = VALUE_W + CW + 1;
  localparam int PROD_W = 2 * CNT_REG_W;
  localparam logic [CW-1:0]     CNT_END  = CW'(CAPACITY);
  localparam logic [CW-1:0]     CNT_LAST = CW'(CAPACITY - 1);
  localparam logic [PROD_W-1:0] CAP_WIDE = PROD_W'(CAPACITY);

  back_state_t state;
  back_state_t state_next;
  back_state_t idle_target;
  status_t     idle_status;

  cls_t                      q_cls;
  logic [INDEX_BITS-1:0]     q_row;
  logic [INDEX_BITS-1:0]     q_col;
  logic [VALUE_W-1:0]        q_value;

  op_t                       op_q;
  logic [INDEX_BITS-1:0]     r_q;
  logic [INDEX_BITS-1:0]     c_q;
  logic [VALUE_W-1:0]        v_q;
  logic                      scanned;
  status_t                   status_pre;
  logic                      found;
  logic                      free_found;
  logic [AW-1:0]             free_addr;
  logic [VALUE_W-1:0]        val_cap;
  logic signed [ACC_W-1:0]   acc;
  logic [CW-1:0]             used_count;
  logic [CW-1:0]             limit;
  logic [PROD_W-1:0]         prod;
  logic                      full;

  logic [CW-1:0]             cnt;
  logic                      pend;
  logic [AW-1:0]             pend_addr;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [WORD_W-1:0]         ram_wdata;
  logic [WORD_W-1:0]         rd_word;
  logic                      rd_valid;
  logic [INDEX_BITS-1:0]     rd_row;
  logic [INDEX_BITS-1:0]     rd_col;
  logic [VALUE_W-1:0]        rd_value;
  logic                      match_pos;
  logic                      match_axis;

  logic                      go;
  logic                      ins_write;
  logic [VALUE_W-1:0]        fin_value;
  status_t                   fin_status;
  logic                      fin_sat;
  logic [ACC_W-VALUE_W:0]    acc_hi;
  logic                      no_clip;

  logic                      resp_valid;
  logic [VALUE_W-1:0]        resp_value;
  status_t                   resp_status;
  logic                      resp_sat;

  assign {q_cls, q_row, q_col, q_value} = pop_data;
  assign {rd_valid, rd_row, rd_col, rd_value} = rd_word;

  assign prod = PROD_W'(row_count) * PROD_W'(col_count);
  assign full = (used_count >= limit);

  assign match_pos  = rd_valid && (rd_row == r_q) && (rd_col == c_q);
  assign match_axis = rd_valid && ((op_q == OP_ROW_SUM) ? (rd_row == r_q) : (rd_col == c_q));

  assign go      = (state == BK_FINISH) && (!resp_valid || response.ready);
  assign acc_hi  = acc[ACC_W-1:VALUE_W-1];
  assign no_clip = (&acc_hi) || !(|acc_hi);

  smcs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CAPACITY)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cnt[AW-1:0]),
    .rdata(rd_word)
  );

  always_comb begin
    idle_target = BK_FINISH;
    idle_status = ST_OK;
    case (q_cls.op)
      OP_INSERT: begin
        if (full) begin
          idle_status = ST_FULL;
        end else if (!q_cls.row_ok || !q_cls.col_ok) begin
          idle_status = ST_RANGE;
        end else begin
          idle_target = BK_SCAN;
        end
      end
      OP_READ, OP_OVERWRITE: begin
        if (q_cls.row_ok && q_cls.col_ok) begin
          idle_target = BK_SCAN;
        end else begin
          idle_status = ST_RANGE;
        end
      end
      OP_ROW_SUM: begin
        if (q_cls.row_ok) begin
          idle_target = BK_SCAN;
        end else begin
          idle_status = ST_RANGE;
        end
      end
      OP_COL_SUM: begin
        if (q_cls.col_ok) begin
          idle_target = BK_SCAN;
        end else begin
          idle_status = ST_RANGE;
        end
      end
      OP_CLEAR: idle_target = BK_CLEAR;
      default: ;
    endcase
  end

  always_comb begin
    fin_value  = '0;
    fin_status = status_pre;
    fin_sat    = 1'b0;
    ins_write  = 1'b0;
    if (scanned) begin
      case (op_q)
        OP_INSERT: begin
          if (found) begin
            fin_status = ST_USED;
          end else if (!free_found) begin
            fin_status = ST_FULL;
          end else begin
            fin_status = ST_OK;
            ins_write  = go;
          end
        end
        OP_READ: begin
          fin_status = ST_OK;
          fin_value  = val_cap;
        end
        OP_ROW_SUM, OP_COL_SUM: begin
          fin_status = ST_OK;
          if (no_clip) begin
            fin_value = acc[VALUE_W-1:0];
          end else begin
            fin_sat   = 1'b1;
            fin_value = acc[ACC_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
          end
        end
        OP_OVERWRITE: fin_status = found ? ST_OK : ST_MISSING;
        default: ;
      endcase
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt[AW-1:0];
    ram_wdata = {1'b1, r_q, c_q, v_q};
    if (state == BK_INIT || state == BK_CLEAR) begin
      ram_we    = 1'b1;
      ram_wdata = '0;
    end else if (state == BK_SCAN && pend && op_q == OP_OVERWRITE && match_pos) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr;
    end else if (ins_write) begin
      ram_we    = 1'b1;
      ram_waddr = free_addr;
    end
  end

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    case (state)
      BK_INIT: begin
        if (cnt == CNT_LAST) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) state_next = idle_target;
      end
      BK_SCAN: begin
        if (cnt == CNT_END && !pend) state_next = BK_FINISH;
      end
      BK_CLEAR: begin
        if (cnt == CNT_LAST) state_next = BK_FINISH;
      end
      BK_FINISH: begin
        if (go) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    limit     <= (prod > CAP_WIDE) ? CNT_END : prod[CW-1:0];
    pend_addr <= cnt[AW-1:0];
    if (go) begin
      resp_value  <= fin_value;
      resp_status <= fin_status;
      resp_sat    <= fin_sat;
    end
    if (rst) begin
      cnt        <= '0;
      pend       <= 1'b0;
      used_count <= '0;
      resp_valid <= 1'b0;
    end else begin
      pend <= (state == BK_SCAN) && (cnt != CNT_END);
      if (go) begin
        resp_valid <= 1'b1;
      end else if (response.ready) begin
        resp_valid <= 1'b0;
      end
      case (state)
        BK_INIT, BK_CLEAR: begin
          cnt <= (cnt == CNT_LAST) ? '0 : cnt + 1'b1;
          if (state == BK_CLEAR) used_count <= '0;
        end
        BK_IDLE: begin
          if (pop_valid) begin
            op_q       <= q_cls.op;
            r_q        <= q_row;
            c_q        <= q_col;
            v_q        <= q_value;
            scanned    <= (idle_target == BK_SCAN);
            status_pre <= idle_status;
            cnt        <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            val_cap    <= '0;
            acc        <= '0;
          end
        end
        BK_SCAN: begin
          if (cnt != CNT_END) cnt <= cnt + 1'b1;
          if (pend) begin
            if (match_pos) begin
              found   <= 1'b1;
              val_cap <= rd_value;
            end
            if (!rd_valid && !free_found) begin
              free_found <= 1'b1;
              free_addr  <= pend_addr;
            end
            if (op_q inside {OP_ROW_SUM, OP_COL_SUM} && match_axis) begin
              acc <= acc + {{(ACC_W-VALUE_W){rd_value[VALUE_W-1]}}, rd_value};
            end
          end
        end
        BK_FINISH: begin
          if (ins_write) used_count <= used_count + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign response.valid        = resp_valid;
  assign response.result_value = resp_value;
  assign response.status       = resp_status;
  assign response.saturated    = resp_sat;

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CNT_END)
    else $error("used slot count above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == BK_CLEAR && state_next == BK_FINISH) |=> (used_count == '0))
    else $error("clear left slots counted");

  a_used_step: assert property (@(posedge clk) disable iff (rst)
    $past(rst) || $past(state) == BK_CLEAR || used_count == $past(used_count)
    || used_count == $past(used_count) + 1'b1)
    else $error("used slot count jumped");

  a_pend_in_scan: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == BK_SCAN))
    else $error("memory read pending outside scan");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(resp_valid) |-> ($past(state) == BK_FINISH))
    else $error("result raised outside finish");

endmodule

FILE: hdl/sparse_matrix_coordinate_store.sv
// Coordinate-list sparse matrix store: top level.
// Coordinate-list sparse matrix store: insert, read, row/column sum and overwrite scan
// every slot between accept and result, with one slot memory read per cycle; range, full
// and unknown operations skip the scan, and clear sweeps every slot instead. The back part
// takes no new item until the last result is registered; a two-item queue takes items meanwhile.
// Reset: synchronous; a sweep invalidates all slots before the first item runs.
module sparse_matrix_coordinate_store import smcs_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic        clk,
  input  logic        rst,
  smcs_cfg_if.sink    cfg,
  smcs_req_if.sink    request,
  smcs_rsp_if.source  response
);

  localparam int ENTRY_W = $bits(cls_t) + 2 * INDEX_BITS + VALUE_W;

  logic                 push_valid;
  logic                 push_ready;
  logic [ENTRY_W-1:0]   push_data;
  logic                 pop_valid;
  logic                 pop_ready;
  logic [ENTRY_W-1:0]   pop_data;
  logic [CNT_REG_W-1:0] row_count;
  logic [CNT_REG_W-1:0] col_count;

  smcs_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .request   (request),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .row_count (row_count),
    .col_count (col_count)
  );

  smcs_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  smcs_back #(
    .CAPACITY  (CAPACITY),
    .INDEX_BITS(INDEX_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .row_count(row_count),
    .col_count(col_count),
    .response (response)
  );

endmodule
